FILE: sv/tlik_pkg.sv
// Shared types, constants and datapath step functions for the planar arm IK pipeline.
// No dependencies; imported by three_link_planar_arm_ik, arm_ik_checker and the testbench.

package tlik_pkg;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_SHOULDER = 2'd0;
	localparam logic [1:0] REG_ELBOW    = 2'd1;
	localparam logic [1:0] REG_WRIST    = 2'd2;

	localparam int LEN_W  = 15;
	localparam int FLD_W  = 16;
	localparam int CRD_W  = 34;   // CORDIC x/y/z
	localparam int ANG_W  = 37;   // angle sums, Q.30 radians
	localparam int DIV_W  = 44;   // divider remainder
	localparam int DEN_W  = 41;   // divider denominator
	localparam int QUO_W  = 31;   // ratio, 0 .. 2^30
	localparam int SQN_W  = 62;   // square root radicand
	localparam int SQR_W  = 34;   // square root remainder
	localparam int SQT_W  = 32;   // square root result
	localparam int STEPS  = 30;

	localparam logic [LEN_W-1:0] LEN_RESET = 15'd256;

	localparam logic signed [ANG_W-1:0] ANG_PI      = 37'sd3373259426;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 37'sd1686629713;
	localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 37'sd6746518852;
	localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

	localparam logic [31:0] ATAN_TAB [STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
	};

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [CRD_W-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic [SQN_W-1:0] n;
		logic [SQR_W-1:0] rem;
		logic [SQT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [DIV_W-1:0] r;
		logic [DEN_W-1:0] d;
		logic [QUO_W-1:0] q;
	} div_t;

	typedef struct packed {
		logic [FLD_W-1:0] base_joint;
		logic [FLD_W-1:0] middle_joint;
		logic [FLD_W-1:0] end_joint;
		logic             unreachable;
	} result_t;

	// Rotation step: drive z toward zero.
	function automatic cordic_t rot_step(cordic_t c, logic [4:0] i);
		logic signed [CRD_W-1:0] x, y, z, dx, dy, at;
		cordic_t o;
		x = c.x;
		y = c.y;
		z = c.z;
		dx = y >>> i;
		dy = x >>> i;
		at = signed'({2'b00, ATAN_TAB[i]});
		if (!z[CRD_W-1]) begin
			o.x = x - dx;
			o.y = y + dy;
			o.z = z - at;
		end else begin
			o.x = x + dx;
			o.y = y - dy;
			o.z = z + at;
		end
		return o;
	endfunction

	// Vectoring step: drive y toward zero, accumulate angle.
	function automatic cordic_t vec_step(cordic_t c, logic [4:0] i);
		logic signed [CRD_W-1:0] x, y, z, dx, dy, at;
		cordic_t o;
		x = c.x;
		y = c.y;
		z = c.z;
		dx = y >>> i;
		dy = x >>> i;
		at = signed'({2'b00, ATAN_TAB[i]});
		if (!y[CRD_W-1]) begin
			o.x = x + dx;
			o.y = y - dy;
			o.z = z + at;
		end else begin
			o.x = x - dx;
			o.y = y + dy;
			o.z = z - at;
		end
		return o;
	endfunction

	// One result bit of a floor square root; radicand consumed two bits from the top.
	function automatic sqrt_t sqrt_step(sqrt_t c);
		logic [SQR_W+1:0] rn, tr;
		sqrt_t o;
		rn = {c.rem, c.n[SQN_W-1 -: 2]};
		tr = {2'b00, c.root, 2'b01};
		o.n = {c.n[SQN_W-3:0], 2'b00};
		if (rn >= tr) begin
			o.rem = SQR_W'(rn - tr);
			o.root = {c.root[SQT_W-2:0], 1'b1};
		end else begin
			o.rem = rn[SQR_W-1:0];
			o.root = {c.root[SQT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// One quotient bit of a restoring divide, remainder kept below d.
	function automatic div_t div_step(div_t c);
		logic [DIV_W-1:0] r2;
		div_t o;
		r2 = {c.r[DIV_W-2:0], 1'b0};
		o.d = c.d;
		if (r2 >= DIV_W'(c.d)) begin
			o.r = r2 - DIV_W'(c.d);
			o.q = {c.q[QUO_W-2:0], 1'b1};
		end else begin
			o.r = r2;
			o.q = {c.q[QUO_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// Q.30 to Q3.12, round half up, saturate.
	function automatic logic [FLD_W-1:0] to_q312(logic signed [ANG_W-1:0] v);
		logic signed [ANG_W-1:0] r;
		r = (v + 37'sd131072) >>> 18;
		if (r > 37'sd32767)
			return 16'h7FFF;
		else if (r < -37'sd32768)
			return 16'h8000;
		else
			return r[FLD_W-1:0];
	endfunction

endpackage

FILE: sv/three_link_planar_arm_ik.sv
// Planar three-link arm inverse kinematics, fully pipelined datapath.
// Depends on tlik_pkg (types, CORDIC/sqrt/divide step functions, constants).
//
// Throughput: one transaction per cycle while the skid slot is empty; set by the
//   unrolled CORDIC, square root and divider stages, one iteration per register stage.
// Reset: arst_n clears all valid bits, including the output and skid valid flags, and loads all
//   three link lengths with 1.0 (256).

module three_link_planar_arm_ik (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [14:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // target_x[15:0], target_y[31:16], approach_angle[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // base_joint[15:0], middle_joint[31:16], end_joint[47:32]
	output logic [0:0]  m_tuser    // unreachable[0]
);
	import tlik_pkg::*;

	localparam int NST = 163;

	// Configuration registers and derived squares (the squares are registered, and their sum
	// and difference registered from them, well ahead of the stage that reads them).
	logic [LEN_W-1:0]        shoulder_q, elbow_q, wrist_q;
	logic [29:0]             ssq_q, esq_q;
	logic [30:0]             es2_q, sse_q;
	logic signed [30:0]      sde_q;

	// Pipeline control
	logic                    en;
	logic                    vld_s [1:NST];

	// Angle fold and sin/cos
	logic [FLD_W-1:0]        x_s [1:34];
	logic [FLD_W-1:0]        y_s [1:34];
	logic [FLD_W-1:0]        alpha_s [1:160];
	logic signed [ANG_W-1:0] wrap_s1;
	logic                    flip_s [2:33];
	cordic_t                 sc_s [2:32];

	// Wrist back-off
	logic signed [49:0]      pc_s33, ps_s33, tc_s34, ts_s34;
	logic signed [17:0]      m_s35, n_s35;

	// atan(n/m)
	cordic_t                 at_s [36:66];
	logic [1:0]              fl_s [36:66];   // {m is zero, n positive}
	logic signed [CRD_W-1:0] t_s [67:160];

	// Reach and law-of-cosines ratios
	logic [33:0]             mm_s36, nn_s36;
	logic [33:0]             l2_s [37:62];
	sqrt_t                   rt1_s [37:62];
	logic signed [44:0]      num_s63 [2];
	logic [DEN_W-1:0]        den_s63 [2];
	logic [DIV_W-1:0]        abs_s64 [2];
	logic [DEN_W-1:0]        den_s64 [2];
	logic                    neg_s [2][64:159];
	logic                    fail [2];
	div_t                    dv_s [2][65:95];
	logic                    unr_s [36:162];

	// acos
	logic [QUO_W-1:0]        q_s [2][96:128];
	logic [61:0]             csq_s96 [2];
	sqrt_t                   rt2_s [2][97:128];
	cordic_t                 ac_s [2][129:159];
	logic signed [ANG_W-1:0] acos_s160 [2];

	// Joint sums
	logic signed [ANG_W-1:0] phi1_s161, phi2_s161, pa_s161;
	logic signed [ANG_W-1:0] o0_s162, o1_s162, o2_s162;
	result_t                 res_s163;

	// Output register and skid slot
	result_t                 out_q, skid_q;
	logic                    out_v_q, skid_v_q;

	logic signed [ANG_W-1:0] a_in, w_half;
	logic                    flip_in;
	logic [24:0]             lq;

	// ---------------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shoulder_q <= LEN_RESET;
			elbow_q <= LEN_RESET;
			wrist_q <= LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SHOULDER: shoulder_q <= cfg_wdata;
				REG_ELBOW:    elbow_q <= cfg_wdata;
				REG_WRIST:    wrist_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ssq_q <= shoulder_q * shoulder_q;
		esq_q <= elbow_q * elbow_q;
		es2_q <= (elbow_q * shoulder_q) << 1;
		sse_q <= 31'(ssq_q) + 31'(esq_q);
		sde_q <= signed'(31'(ssq_q)) - signed'(31'(esq_q));
	end

	// ---------------------------------------------------------------------
	// Flow control: the whole pipe advances unless the skid slot is holding
	// a result, so a new transaction is taken while the output register waits.
	// ---------------------------------------------------------------------
	assign en = !skid_v_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_tvalid;
			for (int k = 2; k <= NST; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	// ---------------------------------------------------------------------
	// Angle folding: wrap into [-pi, pi], then into [-pi/2, pi/2] with a flip.
	// ---------------------------------------------------------------------
	assign a_in = {{3{s_tdata[47]}}, s_tdata[47:32], 18'b0};

	always_comb begin
		w_half = wrap_s1;
		flip_in = 1'b0;
		priority if (wrap_s1 > ANG_HALF_PI) begin
			w_half = wrap_s1 - ANG_PI;
			flip_in = 1'b1;
		end else if (wrap_s1 < -ANG_HALF_PI) begin
			w_half = wrap_s1 + ANG_PI;
			flip_in = 1'b1;
		end
	end

	assign lq = rt1_s[62].root[24:0];

	always_comb begin
		for (int c = 0; c < 2; c++)
			fail[c] = (den_s64[c] == '0) || (abs_s64[c] > DIV_W'(den_s64[c]));
	end

	// ---------------------------------------------------------------------
	// Datapath
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: capture, coarse wrap
			x_s[1] <= s_tdata[15:0];
			y_s[1] <= s_tdata[31:16];
			alpha_s[1] <= s_tdata[47:32];
			priority if (a_in > ANG_PI)
				wrap_s1 <= a_in - ANG_TWO_PI;
			else if (a_in < -ANG_PI)
				wrap_s1 <= a_in + ANG_TWO_PI;
			else
				wrap_s1 <= a_in;
			for (int k = 2; k <= 34; k++) begin
				x_s[k] <= x_s[k-1];
				y_s[k] <= y_s[k-1];
			end
			for (int k = 2; k <= 160; k++)
				alpha_s[k] <= alpha_s[k-1];

			// stages 2..32: sin/cos rotation
			sc_s[2] <= '{x: CORDIC_GAIN, y: '0, z: CRD_W'(w_half)};
			flip_s[2] <= flip_in;
			for (int k = 3; k <= 33; k++)
				flip_s[k] <= flip_s[k-1];
			for (int k = 3; k <= 32; k++)
				sc_s[k] <= rot_step(sc_s[k-1], 5'(k - 3));

			// stages 33..35: W*cos, W*sin, sign flip, round, subtract
			pc_s33 <= signed'({1'b0, wrist_q}) * signed'(sc_s[32].x);
			ps_s33 <= signed'({1'b0, wrist_q}) * signed'(sc_s[32].y);
			tc_s34 <= flip_s[33] ? (50'sd536870912 - pc_s33) : (pc_s33 + 50'sd536870912);
			ts_s34 <= flip_s[33] ? (50'sd536870912 - ps_s33) : (ps_s33 + 50'sd536870912);
			m_s35 <= 18'(signed'(x_s[34])) - 18'(tc_s34 >>> 30);
			n_s35 <= 18'(signed'(y_s[34])) - 18'(ts_s34 >>> 30);

			// stages 36..67: atan(n/m), vertical reach handled by flags
			at_s[36].x <= CRD_W'(signed'(m_s35[17] ? -m_s35 : m_s35)) <<< 12;
			at_s[36].y <= CRD_W'(signed'(m_s35[17] ? -19'(n_s35) : 19'(n_s35))) <<< 12;
			at_s[36].z <= '0;
			fl_s[36] <= {m_s35 == '0, !n_s35[17] && (n_s35 != '0)};
			for (int k = 37; k <= 66; k++) begin
				at_s[k] <= vec_step(at_s[k-1], 5'(k - 37));
				fl_s[k] <= fl_s[k-1];
			end
			if (fl_s[66][1])
				t_s[67] <= fl_s[66][0] ? CRD_W'(ANG_HALF_PI) : CRD_W'(-ANG_HALF_PI);
			else
				t_s[67] <= at_s[66].z;
			for (int k = 68; k <= 160; k++)
				t_s[k] <= t_s[k-1];

			// stages 36..62: l^2 and floor(sqrt(l^2 * 2^16))
			mm_s36 <= 34'(m_s35 * m_s35);
			nn_s36 <= 34'(n_s35 * n_s35);
			l2_s[37] <= mm_s36 + nn_s36;
			rt1_s[37] <= '{n: {mm_s36 + nn_s36, 28'b0}, rem: '0, root: '0};
			for (int k = 38; k <= 62; k++) begin
				rt1_s[k] <= sqrt_step(rt1_s[k-1]);
				l2_s[k] <= l2_s[k-1];
			end

			// stage 63: numerators and denominators of both cosines
			den_s63[0] <= (lq * shoulder_q) << 1;
			den_s63[1] <= DEN_W'(es2_q);
			num_s63[0] <= (45'(sde_q) + signed'(45'(l2_s[62]))) <<< 8;
			num_s63[1] <= signed'(45'(sse_q)) - signed'(45'(l2_s[62]));

			// stages 64..95: magnitude, range check, 30-bit divide
			for (int c = 0; c < 2; c++) begin
				abs_s64[c] <= DIV_W'(num_s63[c][44] ? -num_s63[c] : num_s63[c]);
				neg_s[c][64] <= num_s63[c][44];
				den_s64[c] <= den_s63[c];
				// a ratio of exactly one seeds the quotient so it ends at 2^30
				if (abs_s64[c] == DIV_W'(den_s64[c]))
					dv_s[c][65] <= '{r: '0, d: den_s64[c], q: QUO_W'(1)};
				else
					dv_s[c][65] <= '{r: abs_s64[c], d: den_s64[c], q: '0};
				for (int k = 66; k <= 95; k++)
					dv_s[c][k] <= div_step(dv_s[c][k-1]);
				for (int k = 65; k <= 95; k++)
					neg_s[c][k] <= neg_s[c][k-1];

				// stages 96..128: sine term floor(sqrt(2^60 - c^2))
				q_s[c][96] <= dv_s[c][95].q;
				neg_s[c][96] <= neg_s[c][95] && (dv_s[c][95].q != '0);
				csq_s96[c] <= dv_s[c][95].q * dv_s[c][95].q;
				for (int k = 97; k <= 159; k++)
					neg_s[c][k] <= neg_s[c][k-1];
				for (int k = 97; k <= 128; k++)
					q_s[c][k] <= q_s[c][k-1];
				rt2_s[c][97] <= '{n: (62'd1 << 60) - csq_s96[c], rem: '0, root: '0};
				for (int k = 98; k <= 128; k++)
					rt2_s[c][k] <= sqrt_step(rt2_s[c][k-1]);

				// stages 129..160: acos angle, reflected for a negative cosine
				ac_s[c][129] <= '{x: CRD_W'(q_s[c][128]), y: CRD_W'(rt2_s[c][128].root), z: '0};
				for (int k = 130; k <= 159; k++)
					ac_s[c][k] <= vec_step(ac_s[c][k-1], 5'(k - 130));
				acos_s160[c] <= neg_s[c][159] ? (ANG_PI - ANG_W'(signed'(ac_s[c][159].z)))
					: ANG_W'(signed'(ac_s[c][159].z));
			end

			// unreachable: zero reach at stage 36, ratio out of range or zero denominator at stage 65
			unr_s[36] <= (m_s35 == '0) && (n_s35 == '0);
			for (int k = 37; k <= 162; k++)
				unr_s[k] <= (k == 65) ? (unr_s[k-1] || fail[0] || fail[1]) : unr_s[k-1];

			// stages 161..163: joint angles, offsets, rounding
			phi1_s161 <= ANG_W'(signed'(t_s[160])) + acos_s160[0];
			phi2_s161 <= acos_s160[1];
			pa_s161 <= ANG_PI + {{3{alpha_s[160][15]}}, alpha_s[160], 18'b0};
			o0_s162 <= phi1_s161 - ANG_HALF_PI;
			o1_s162 <= phi2_s161 - ANG_HALF_PI;
			o2_s162 <= pa_s161 - phi1_s161 - phi2_s161;
			res_s163.unreachable <= unr_s[162];
			res_s163.base_joint <= unr_s[162] ? '0 : to_q312(o0_s162);
			res_s163.middle_joint <= unr_s[162] ? '0 : to_q312(o1_s162);
			res_s163.end_joint <= unr_s[162] ? '0 : to_q312(o2_s162);
		end
	end

	// ---------------------------------------------------------------------
	// Output register with one-entry skid
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !m_tready) begin
			if (en && vld_s[NST])
				skid_v_q <= 1'b1;
		end else if (skid_v_q) begin
			out_v_q <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= vld_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !m_tready) begin
			if (en && vld_s[NST])
				skid_q <= res_s163;
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= res_s163;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {out_q.end_joint, out_q.middle_joint, out_q.base_joint};
	assign m_tuser = out_q.unreachable;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid slot full while output register empty");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid slot filled without an output stall");

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.unreachable) |-> (m_tdata == '0))
		else $error("unreachable result carries nonzero joint angles");

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[2] |-> ((ANG_W'(signed'(sc_s[2].z)) <= ANG_HALF_PI)
			&& (ANG_W'(signed'(sc_s[2].z)) >= -ANG_HALF_PI)))
		else $error("folded approach angle outside half-pi range");

endmodule

FILE: dv/arm_ik_checker.sv
`timescale 1ns / 1ps
// Checker for the planar arm IK block: watches config writes, input and output streams,
// predicts joint angles with its own integer CORDIC model. Depends on tlik_pkg.

module arm_ik_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [14:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [0:0]  m_tuser,
	output int          fail_count,
	output int          pending
);
	import tlik_pkg::*;

	typedef struct {
		logic [15:0] base;
		logic [15:0] middle;
		logic [15:0] wrist;
		logic        unreach;
	} joints_t;

	localparam longint PI_Q30   = 64'sd3373259426;
	localparam longint HALF_Q30 = 64'sd1686629713;
	localparam longint TWO_Q30  = 64'sd6746518852;

	longint  arm_s, arm_e, arm_w;
	joints_t joints_q[$];

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint vec_angle(longint x, longint y);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	function automatic longint arc_cos(longint c);
		longint s;
		s = longint'(int_sqrt((64'd1 << 60) - longint'(c * c)));
		if (c >= 0) return vec_angle(c, s);
		return PI_Q30 - vec_angle(-c, s);
	endfunction

	// Ratio in Q.30; returns 0 when out of [-1,1] or den not positive.
	function automatic bit cos_ratio(longint num, longint den, output longint c);
		longint unsigned r, d, q;
		c = 0;
		if (den <= 0) return 0;
		r = num < 0 ? -num : num;
		d = den;
		if (r > d) return 0;
		q = 0;
		if (r == d) q = 64'd1 << 30;
		else for (int i = 0; i < 30; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= d) begin
				r -= d;
				q |= 1;
			end
		end
		c = num < 0 ? -longint'(q) : longint'(q);
		return 1;
	endfunction

	function automatic logic [15:0] q312(longint v);
		longint r;
		r = fshr(v + 131072, 18);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic joints_t solve_arm(logic [47:0] d);
		longint x, y, a30, ar, cx, sy, dx, dy, m, n, t, l2, lq, c1, c2, p1, p2;
		bit flip;
		joints_t o;
		x = longint'($signed(d[15:0]));
		y = longint'($signed(d[31:16]));
		a30 = longint'($signed(d[47:32])) * 262144;
		o = '{16'h0, 16'h0, 16'h0, 1'b1};
		ar = a30;
		flip = 0;
		if (ar > PI_Q30) ar -= TWO_Q30;
		if (ar < -PI_Q30) ar += TWO_Q30;
		if (ar > HALF_Q30) begin
			ar -= PI_Q30; flip = 1;
		end else if (ar < -HALF_Q30) begin
			ar += PI_Q30; flip = 1;
		end
		cx = 64'sh26DD3B6A;
		sy = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = fshr(sy, i);
			dy = fshr(cx, i);
			if (ar >= 0) begin
				cx -= dx; sy += dy; ar -= longint'(ATAN_TAB[i]);
			end else begin
				cx += dx; sy -= dy; ar += longint'(ATAN_TAB[i]);
			end
		end
		if (flip) begin
			cx = -cx; sy = -sy;
		end
		m = x - fshr(arm_w * cx + (64'sd1 << 29), 30);
		n = y - fshr(arm_w * sy + (64'sd1 << 29), 30);
		if (m == 0 && n == 0) return o;
		if (m == 0) t = n > 0 ? HALF_Q30 : -HALF_Q30;
		else if (m > 0) t = vec_angle(m * 4096, n * 4096);
		else t = vec_angle(-m * 4096, -n * 4096);
		l2 = m * m + n * n;
		lq = longint'(int_sqrt(longint'(l2) << 16));
		if (!cos_ratio((arm_s * arm_s + l2 - arm_e * arm_e) * 256, 2 * lq * arm_s, c1))
			return o;
		if (!cos_ratio(arm_e * arm_e + arm_s * arm_s - l2, 2 * arm_e * arm_s, c2))
			return o;
		p1 = t + arc_cos(c1);
		p2 = arc_cos(c2);
		o.base = q312(p1 - HALF_Q30);
		o.middle = q312(p2 - HALF_Q30);
		o.wrist = q312(PI_Q30 - p1 - p2 + a30);
		o.unreach = 0;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		joints_t w;
		if (!arst_n) begin
			arm_s = 256;
			arm_e = 256;
			arm_w = 256;
			fail_count = 0;
			joints_q.delete();
		end else begin
			// config first: the block must be kept idle whenever a write happens; the block itself does not enforce it
			if (cfg_we) begin
				case (cfg_addr)
					REG_SHOULDER: arm_s = cfg_wdata;
					REG_ELBOW:    arm_e = cfg_wdata;
					REG_WRIST:    arm_w = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				joints_q.push_back(solve_arm(s_tdata));
			if (m_tvalid && m_tready) begin
				if (joints_q.size() == 0) begin
					$display("unexpected output transaction at %0t", $realtime);
					fail_count++;
				end else begin
					w = joints_q.pop_front();
					if (m_tuser[0] !== w.unreach)
						report_mismatch("unreachable", {15'h0, m_tuser[0]}, {15'h0, w.unreach});
					if (m_tdata[15:0] !== w.base)
						report_mismatch("base_joint", m_tdata[15:0], w.base);
					if (m_tdata[31:16] !== w.middle)
						report_mismatch("middle_joint", m_tdata[31:16], w.middle);
					if (m_tdata[47:32] !== w.wrist)
						report_mismatch("end_joint", m_tdata[47:32], w.wrist);
				end
			end
		end
		pending = joints_q.size();
	end

endmodule

FILE: dv/tb_three_link_planar_arm_ik.sv
`timescale 1ns / 1ps
// Testbench top for three_link_planar_arm_ik: clock, reset, config phases, stimulus
// and verdict. Depends on tlik_pkg, the block and arm_ik_checker.

module tb_three_link_planar_arm_ik;
	import tlik_pkg::*;

	localparam int LATENCY   = 163;
	localparam int STALL_MAX = 5000;   // cycles with no transaction before giving up

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_addr = REG_SHOULDER;
	logic [14:0] cfg_wdata = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;    // target_x, target_y, approach_angle
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;         // base_joint, middle_joint, end_joint
	logic [0:0]  m_tuser;         // unreachable
	int          fail_count, pending;
	bit          no_idle = 0;     // burst window with no idling on either side
	bit          hold_off = 0;    // receiver back-pressure window
	int          quiet = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	three_link_planar_arm_ik dut (.*);
	arm_ik_checker chk (.*);

	// Receiver: random stalls, plus a long hold-off when asked.
	always @(negedge clk) begin
		if (hold_off)
			m_tready <= 0;
		else
			m_tready <= no_idle || ($urandom_range(99) >= 18);
	end

	// Watchdog on cycles with no transaction at all.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > STALL_MAX) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [14:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// One transaction; optional random gap before it. Driven at the falling edge.
	task automatic send_target(logic [15:0] x, logic [15:0] y, logic [15:0] a);
		while (!no_idle && $urandom_range(99) < 18)
			@(negedge clk);
		s_tvalid = 1;
		s_tdata = {a, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	// Mostly in-reach targets near the arm's workspace, some full-range noise.
	task automatic random_targets(int count, int reach);
		logic [15:0] x, y, a;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) < 7) begin
				x = 16'($signed($urandom_range(2 * reach)) - reach);
				y = 16'($signed($urandom_range(2 * reach)) - reach);
				a = 16'($signed($urandom_range(25736)) - 12868);
			end else begin
				x = 16'($urandom);
				y = 16'($urandom);
				a = 16'($urandom);
			end
			send_target(x, y, a);
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1;

		// Directed, reset lengths 1.0 each.
		send_target(16'h0100, 16'h0000, 16'h0000);   // wrist backs off onto the origin
		send_target(16'h0180, 16'h0000, 16'h0000);
		send_target(16'h0100, 16'h0200, 16'h1922);   // alpha = pi/2, wrist link pointing up
		send_target(16'h0100, 16'hFE00, 16'hE6DE);   // alpha = -pi/2, wrist link pointing down
		send_target(16'hFF00, 16'h0080, 16'h8000);   // negative m, alpha most negative
		send_target(16'h0000, 16'h0180, 16'h7FFF);   // alpha beyond pi, folded
		send_target(16'h7FFF, 16'h7FFF, 16'h0000);   // far out of reach
		send_target(16'h8000, 16'h8000, 16'h8000);
		send_target(16'h0200, 16'h0100, 16'h0000);   // in reach, wrist point at (1.0, 1.0)
		send_target(16'h0140, 16'h00C0, 16'h4000);
		send_target(16'hFFFF, 16'h0001, 16'hFFFF);
		send_target(16'h0000, 16'h0000, 16'h3244);   // alpha just above pi
		wait_drained();

		// Zero shoulder gives a zero denominator.
		write_reg(REG_SHOULDER, 15'd0);
		write_reg(REG_WRIST, 15'd0);
		send_target(16'h0100, 16'h0000, 16'h0000);
		send_target(16'h0000, 16'h0000, 16'h0000);   // origin with zero wrist
		wait_drained();
		write_reg(REG_SHOULDER, 15'd256);
		write_reg(REG_ELBOW, 15'd0);
		send_target(16'h0100, 16'h0000, 16'h0000);
		wait_drained();

		// Random phase, reset shoulder and elbow lengths, half-length wrist, with a burst and a long hold-off.
		write_reg(REG_ELBOW, 15'd256);
		write_reg(REG_WRIST, 15'd128);
		random_targets(100, 700);
		no_idle = 1;
		random_targets(60, 700);
		no_idle = 0;
		fork
			begin
				hold_off = 1;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			random_targets(220, 700);
		join
		wait_drained();

		// Extremes of the link lengths.
		write_reg(REG_SHOULDER, 15'h7FFF);
		write_reg(REG_ELBOW, 15'h7FFF);
		write_reg(REG_WRIST, 15'h7FFF);
		random_targets(60, 32767);
		wait_drained();
		write_reg(REG_SHOULDER, 15'd1);
		write_reg(REG_ELBOW, 15'd1);
		write_reg(REG_WRIST, 15'd1);
		random_targets(20, 3);
		wait_drained();
		write_reg(REG_SHOULDER, 15'd5000);
		write_reg(REG_ELBOW, 15'd3000);
		write_reg(REG_WRIST, 15'd700);
		random_targets(60, 9000);
		wait_drained();

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
